// ----- hw/rtl/hpt_pkg.sv -----
// Shared types and constants for the homogeneous point transform.
`default_nettype none

package hpt_pkg;

  localparam int NUM_LANES   = 4;
  localparam int MAT_ENTRIES = 16;
  localparam int IDX_W       = 4;
  localparam int FIELD_W     = 32;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  // Stage enables handed from the top-level control to the lanes and the merge stage.
  typedef struct packed {
    logic en_mul;
    logic en_sum;
    logic en_out;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/homogeneous_point_transform.sv -----
// Top level of the 4x4 fixed-point matrix times vector transform engine.
//
//   channel | direction | handshake                  | beat carries
//   input   | in        | in_valid_i / in_ready_o    | operation, entry index/value, x y z w
//   output  | out       | out_valid_o / out_ready_i  | out x y z w, saturated flag
//
// One beat is accepted per cycle while in_ready_o is high; a transform passes through
// the multiply stage, lane adder stage and saturating output register to the output.
// A load writes its matrix entry at acceptance and produces no output beat.
// Reset puts the identity matrix in place and empties the pipeline.
// A stalled output only blocks the input once every stage behind it is full.
`default_nettype none

module homogeneous_point_transform #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     in_valid_i,
  output logic                                    in_ready_o,
  input  wire                                     operation_i,
  input  wire  [hpt_pkg::IDX_W-1:0]               entry_index_i,
  input  wire  logic signed [hpt_pkg::FIELD_W-1:0] entry_value_i,
  input  wire  logic signed [hpt_pkg::FIELD_W-1:0] vec_x_i,
  input  wire  logic signed [hpt_pkg::FIELD_W-1:0] vec_y_i,
  input  wire  logic signed [hpt_pkg::FIELD_W-1:0] vec_z_i,
  input  wire  logic signed [hpt_pkg::FIELD_W-1:0] vec_w_i,
  output logic                                    out_valid_o,
  input  wire                                     out_ready_i,
  output logic signed [hpt_pkg::FIELD_W-1:0]      out_x_o,
  output logic signed [hpt_pkg::FIELD_W-1:0]      out_y_o,
  output logic signed [hpt_pkg::FIELD_W-1:0]      out_z_o,
  output logic signed [hpt_pkg::FIELD_W-1:0]      out_w_o,
  output logic                                    saturated_o
);
  import hpt_pkg::*;

  localparam int VW = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  // Entries must also hold the reset value of one, which needs FRAC_BITS + 2 bits.
  localparam int EW = (VW >= FRAC_BITS + 2) ? VW : FRAC_BITS + 2;
  localparam int PW = EW + VW;
  localparam int SW = PW - FRAC_BITS + 2;
  localparam logic signed [EW-1:0] ONE_V = EW'(1) << FRAC_BITS;

  logic signed [EW-1:0] matrix_q [MAT_ENTRIES];
  logic signed [VW-1:0] load_v;
  logic signed [VW-1:0] vec    [NUM_LANES];
  logic signed [SW-1:0] lane_sum [NUM_LANES];
  logic [FIELD_W-1:0]   comp   [NUM_LANES];

  logic      mul_vld_q, mul_vld_d;
  logic      sum_vld_q, sum_vld_d;
  logic      out_vld_q, out_vld_d;
  logic      in_fire;
  pipe_ctl_t ctl;

  // Each stage advances when it is empty or the stage after it advances.
  assign ctl.en_out = !out_vld_q || out_ready_i;
  assign ctl.en_sum = !sum_vld_q || ctl.en_out;
  assign ctl.en_mul = !mul_vld_q || ctl.en_sum;
  assign in_ready_o = ctl.en_mul;
  assign in_fire    = in_valid_i && in_ready_o;

  assign mul_vld_d = ctl.en_mul ? (in_fire && (op_e'(operation_i) == OP_XFORM)) : mul_vld_q;
  assign sum_vld_d = ctl.en_sum ? mul_vld_q : sum_vld_q;
  assign out_vld_d = ctl.en_out ? sum_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= mul_vld_d;
      sum_vld_q <= sum_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign load_v = entry_value_i[VW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAT_ENTRIES; k++) begin
        matrix_q[k] <= ((k / NUM_LANES) == (k % NUM_LANES)) ? ONE_V : '0;
      end
    end else if (in_fire && (op_e'(operation_i) == OP_LOAD)) begin
      matrix_q[entry_index_i] <= EW'(load_v);
    end
  end

  assign vec[0] = vec_x_i[VW-1:0];
  assign vec[1] = vec_y_i[VW-1:0];
  assign vec[2] = vec_z_i[VW-1:0];
  assign vec[3] = vec_w_i[VW-1:0];

  for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
    logic signed [EW-1:0] row [NUM_LANES];
    for (genvar c = 0; c < NUM_LANES; c++) begin : g_col
      assign row[c] = matrix_q[c * NUM_LANES + r];
    end
    hpt_lane #(
      .EW   (EW),
      .VW   (VW),
      .FRAC (FRAC_BITS),
      .PW   (PW),
      .SW   (SW)
    ) u_lane (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .row_i (row),
      .vec_i (vec),
      .sum_o (lane_sum[r])
    );
  end

  hpt_merge #(
    .VW (VW),
    .SW (SW)
  ) u_merge (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .sum_i  (lane_sum),
    .comp_o (comp),
    .sat_o  (saturated_o)
  );

  assign out_valid_o = out_vld_q;
  assign out_x_o     = comp[0];
  assign out_y_o     = comp[1];
  assign out_z_o     = comp[2];
  assign out_w_o     = comp[3];

endmodule

`default_nettype wire

// ----- hw/rtl/hpt_lane.sv -----
// One row lane: four products registered, then the floored shifted sum registered.
`default_nettype none

module hpt_lane #(
  parameter int EW   = 32,
  parameter int VW   = 32,
  parameter int FRAC = 16,
  parameter int PW   = EW + VW,
  parameter int SW   = PW - FRAC + 2
) (
  input  wire                       clk_i,
  input  wire hpt_pkg::pipe_ctl_t   ctl_i,
  input  wire logic signed [EW-1:0] row_i [hpt_pkg::NUM_LANES],
  input  wire logic signed [VW-1:0] vec_i [hpt_pkg::NUM_LANES],
  output logic signed [SW-1:0]      sum_o
);
  import hpt_pkg::*;

  logic signed [PW-1:0]      prod_q [NUM_LANES];
  logic signed [PW-FRAC-1:0] shr    [NUM_LANES];
  logic signed [SW-1:0]      sum_d;
  logic signed [SW-1:0]      sum_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_mul) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        prod_q[c] <= row_i[c] * vec_i[c];
      end
    end
  end

  // Dropping the low fraction bits of a two's complement product floors it.
  always_comb begin
    sum_d = '0;
    for (int c = 0; c < NUM_LANES; c++) begin
      shr[c] = prod_q[c][PW-1:FRAC];
      sum_d  = sum_d + SW'(shr[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_sum) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hpt_merge.sv -----
// Merge stage: saturates each lane sum and combines the lane overflow flags.
`default_nettype none

module hpt_merge #(
  parameter int VW = 32,
  parameter int SW = 50
) (
  input  wire                       clk_i,
  input  wire hpt_pkg::pipe_ctl_t   ctl_i,
  input  wire logic signed [SW-1:0] sum_i  [hpt_pkg::NUM_LANES],
  output logic [hpt_pkg::FIELD_W-1:0] comp_o [hpt_pkg::NUM_LANES],
  output logic                      sat_o
);
  import hpt_pkg::*;

  localparam logic signed [VW-1:0] MAX_V = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] MIN_V = {1'b1, {(VW-1){1'b0}}};

  logic signed [VW-1:0] clip [NUM_LANES];
  logic [NUM_LANES-1:0] ovf;
  logic [FIELD_W-1:0]   comp_q [NUM_LANES];
  logic                 sat_q;

  // A sum fits when all bits from the top down to the result's sign bit agree.
  always_comb begin
    for (int r = 0; r < NUM_LANES; r++) begin
      ovf[r] = !((&sum_i[r][SW-1:VW-1]) || !(|sum_i[r][SW-1:VW-1]));
      if (!ovf[r]) begin
        clip[r] = sum_i[r][VW-1:0];
      end else if (sum_i[r][SW-1]) begin
        clip[r] = MIN_V;
      end else begin
        clip[r] = MAX_V;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_out) begin
      for (int r = 0; r < NUM_LANES; r++) begin
        comp_q[r] <= FIELD_W'(clip[r]);
      end
      sat_q <= |ovf;
    end
  end

  assign comp_o = comp_q;
  assign sat_o  = sat_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hpt_checker.sv -----
// Port-level checks for the homogeneous point transform, bound to the top level.
`default_nettype none

module hpt_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_valid_i,
  input wire                              in_ready_o,
  input wire                              operation_i,
  input wire                              out_valid_o,
  input wire                              out_ready_i,
  input wire [hpt_pkg::FIELD_W-1:0]       out_x_o,
  input wire [hpt_pkg::FIELD_W-1:0]       out_y_o,
  input wire [hpt_pkg::FIELD_W-1:0]       out_z_o,
  input wire [hpt_pkg::FIELD_W-1:0]       out_w_o,
  input wire                              saturated_o
);
  import hpt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_x_o) && $stable(out_y_o)
      && $stable(out_z_o) && $stable(out_w_o) && $stable(saturated_o))
    else $error("output payload changed while stalled");

  // The input only stalls when the whole pipeline is backed up behind the output.
  a_ready_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // With the output draining, an accepted transform passes the multiply, sum and output registers to the output.
  a_xform_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_e'(operation_i) == OP_XFORM) && out_ready_i
      ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("transform result missing");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (.*);

`default_nettype wire

// ----- bench/hpt_xform_checker.sv -----
// Checker for the point transform: tracks the matrix, predicts each transform and compares.
module hpt_xform_checker #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  hpt_pkg::op_e        operation_i,
  input  logic [3:0]          entry_index_i,
  input  logic signed [31:0]  entry_value_i,
  input  logic signed [31:0]  vec_x_i,
  input  logic signed [31:0]  vec_y_i,
  input  logic signed [31:0]  vec_z_i,
  input  logic signed [31:0]  vec_w_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic signed [31:0]  out_x_i,
  input  logic signed [31:0]  out_y_i,
  input  logic signed [31:0]  out_z_i,
  input  logic signed [31:0]  out_w_i,
  input  logic                saturated_i,
  output int                  errors_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hpt_pkg::*;

  // The fields carry 32 bits, so wider values are cut back to 32.
  localparam int VBITS = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        clip;
  } xform_res_t;

  longint     matrix_q[16];
  xform_res_t xform_q[$];
  xform_res_t want;

  function automatic longint to_value(input logic [31:0] raw);
    longint t;
    t = longint'({32'b0, raw}) <<< (64 - VBITS);
    return t >>> (64 - VBITS);
  endfunction

  function automatic xform_res_t transform_vec(input logic [31:0] vx, vy, vz, vw);
    longint     vec[4];
    longint     acc;
    longint     hi;
    longint     lo;
    logic [31:0] comp[4];
    logic       clipped;
    xform_res_t res;
    vec[0] = to_value(vx);
    vec[1] = to_value(vy);
    vec[2] = to_value(vz);
    vec[3] = to_value(vw);
    hi = (longint'(1) <<< (VBITS - 1)) - 1;
    lo = -hi - 1;
    clipped = 1'b0;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      // Each product is exact; the arithmetic shift rounds toward minus infinity.
      for (int c = 0; c < 4; c++) begin
        acc += (matrix_q[c * 4 + r] * vec[c]) >>> FRAC_BITS;
      end
      if (acc > hi) begin
        acc = hi;
        clipped = 1'b1;
      end else if (acc < lo) begin
        acc = lo;
        clipped = 1'b1;
      end
      comp[r] = acc[31:0];
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    res.w = comp[3];
    res.clip = clipped;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v, got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        matrix_q[i] = (i % 5 == 0) ? (longint'(1) <<< FRAC_BITS) : 0;
      end
      xform_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (xform_q.size() == 0) begin
          $error("output beat with no transform outstanding");
          errors_o++;
        end else begin
          want = xform_q.pop_front();
          check_field("out_x", want.x, out_x_i);
          check_field("out_y", want.y, out_y_i);
          check_field("out_z", want.z, out_z_i);
          check_field("out_w", want.w, out_w_i);
          check_field("saturated", {31'b0, want.clip}, {31'b0, saturated_i});
        end
      end
      // A load takes effect at acceptance, ahead of any later transform.
      if (in_valid_i && in_ready_i) begin
        if (operation_i == OP_LOAD) begin
          matrix_q[entry_index_i] = to_value(entry_value_i);
        end else begin
          xform_q.push_back(transform_vec(vec_x_i, vec_y_i, vec_z_i, vec_w_i));
        end
      end
      pending_o = xform_q.size();
    end
  end

endmodule

// ----- bench/homogeneous_point_transform_tb.sv -----
// Testbench top for the point transform: stimulus, output back-pressure and the verdict.
module homogeneous_point_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hpt_pkg::*;

  localparam int          PHASE_ITEMS = 360;
  localparam int          QUIET_LIMIT = 1000;
  localparam int          HOLD_CYCLES = 96;
  localparam logic [31:0] Q_ONE       = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE   = 32'hFFFF_0000;
  localparam logic [31:0] V_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] V_MIN       = 32'h8000_0000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  op_e                operation;
  logic [3:0]         entry_index;
  logic signed [31:0] entry_value;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] vec_w;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               saturated;
  int                 errors;
  int                 pending;
  int                 send_idle_pct = 7;
  int                 rcv_idle_pct = 57;
  bit                 hold_out = 1'b0;

  homogeneous_point_transform i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .operation_i  (operation),
    .entry_index_i(entry_index),
    .entry_value_i(entry_value),
    .vec_x_i      (vec_x),
    .vec_y_i      (vec_y),
    .vec_z_i      (vec_z),
    .vec_w_i      (vec_w),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .out_z_o      (out_z),
    .out_w_o      (out_w),
    .saturated_o  (saturated)
  );

  hpt_xform_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .operation_i  (operation),
    .entry_index_i(entry_index),
    .entry_value_i(entry_value),
    .vec_x_i      (vec_x),
    .vec_y_i      (vec_y),
    .vec_z_i      (vec_z),
    .vec_w_i      (vec_w),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_x_i      (out_x),
    .out_y_i      (out_y),
    .out_z_i      (out_z),
    .out_w_i      (out_w),
    .saturated_i  (saturated),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Q16.16 values: mostly moderate magnitudes, with raw bit patterns and corner values mixed in.
  function automatic logic [31:0] pick_q16();
    case ($urandom_range(9))
      0, 1, 2, 3: return int'($urandom_range(524288)) - 262144;
      4, 5:       return $urandom();
      6, 7: begin
        case ($urandom_range(6))
          0:       return '0;
          1:       return Q_ONE;
          2:       return Q_NEG_ONE;
          3:       return V_MAX;
          4:       return V_MIN;
          5:       return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default:    return int'($urandom_range(131072)) - 65536;
    endcase
  endfunction

  task automatic send_beat(input op_e op, input logic [3:0] idx,
                           input logic [31:0] val, x, y, z, w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    entry_index <= idx;
    entry_value <= val;
    vec_x       <= x;
    vec_y       <= y;
    vec_z       <= z;
    vec_w       <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Fields that the operation does not use carry random bits.
  task automatic send_load(input logic [3:0] idx, input logic [31:0] val);
    send_beat(OP_LOAD, idx, val, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic send_xform(input logic [31:0] x, y, z, w);
    send_beat(OP_XFORM, 4'($urandom_range(15)), $urandom(), x, y, z, w);
  endtask

  task automatic random_item();
    logic [31:0] w;
    if ($urandom_range(3) == 0) begin
      send_load(4'($urandom_range(15)), pick_q16());
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: w = Q_ONE;
        5, 6:          w = '0;
        default:       w = pick_q16();
      endcase
      send_xform(pick_q16(), pick_q16(), pick_q16(), w);
    end
  endtask

  // The extra edge lets the checker log a beat accepted at the last edge.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  initial begin
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("homogeneous_point_transform_tb: done, errors");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    operation   <= OP_LOAD;
    entry_index <= '0;
    entry_value <= '0;
    vec_x       <= '0;
    vec_y       <= '0;
    vec_z       <= '0;
    vec_w       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity after reset: a point and the full-scale extremes pass straight through.
    send_xform(Q_ONE, 32'h0002_0000, 32'h0003_0000, Q_ONE);
    send_xform(V_MAX, V_MIN, 32'hFFFF_FFFF, V_MIN);
    // A translation column moves points but leaves directions alone.
    send_load(4'd12, 32'h000A_0000);
    send_load(4'd13, 32'hFFFD_8000);
    send_xform(32'h0001_8000, 32'hFFFF_4000, 32'h0000_0001, Q_ONE);
    send_xform(32'h0001_8000, 32'hFFFF_4000, 32'h0000_0001, '0);
    // The smallest negative entry times a tiny value must round down to -1.
    send_load(4'd0, 32'hFFFF_FFFF);
    send_xform(32'h0000_0001, Q_ONE, '0, '0);
    // Full-scale entries drive the sums past either limit.
    send_load(4'd5, V_MAX);
    send_xform('0, V_MAX, '0, '0);
    send_xform('0, V_MIN, '0, '0);
    send_load(4'd15, V_MIN);
    send_xform('0, '0, '0, V_MIN);
    send_xform('0, '0, '0, V_MAX);
    send_load(4'd3, V_MAX);
    send_load(4'd7, V_MAX);
    send_xform(V_MAX, V_MAX, '0, '0);
    send_load(4'd10, '0);
    send_xform('0, '0, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          rcv_idle_pct  = 57;
        end
        1: begin
          send_idle_pct = 57;
          rcv_idle_pct  = 7;
        end
        default: begin
          send_idle_pct = 0;
          rcv_idle_pct  = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Stall the output for a long stretch while beats keep coming, then drain fully later.
        if (n == 120) hold_out = 1'b1;
        if (n == 250) drain_results();
        random_item();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("homogeneous_point_transform_tb: done, clean");
    end else begin
      $display("homogeneous_point_transform_tb: done, errors");
    end
    $finish;
  end

endmodule
